[hw/rtl/itf_pkg.sv]
// ----------------------------------------------------------------------------
// itf_pkg
// Shared constants, types and character codes for the integer text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

   // Field limits.
   localparam int MAX_FIELD  = 60;
   localparam int VALUE_W    = 64;
   localparam int MODE_W     = 3;
   localparam int FIELD_W    = 6;
   localparam int CHAR_W     = 8;

   // Digit slots: enough nibbles for the longest rendering (octal, 22 digits).
   localparam int SLOT_COUNT = (VALUE_W + 2) / 3;
   localparam int DIGITS_W   = SLOT_COUNT * 4;
   localparam int OCT_EXT_W  = SLOT_COUNT * 3;
   localparam int ND_W       = $clog2(SLOT_COUNT + 1);

   // Decimal conversion: 20 BCD digits cover the full unsigned range.
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = BCD_DIGITS * 4;
   localparam int STEP_W     = $clog2(VALUE_W / 2);

   // Characters per number, prefix included.
   localparam int COUNT_W    = $clog2(MAX_FIELD + 3);

   // Job queue between the converter and the emitter.
   localparam int QUEUE_DEPTH = 2;

   // Conversion modes.
   localparam logic [MODE_W-1:0] MODE_SDEC       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UDEC       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OCT        = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HEX_LOWER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HEX_UPPER  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_POINTER    = 3'd5;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_X_UPPER = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 8'h78;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   // One fully prepared number, ready for character emission.
   typedef struct packed {
      logic [DIGITS_W-1:0]  digits;       // most significant digit in the top nibble
      logic [ND_W-1:0]      num_digits;
      logic [2*CHAR_W-1:0]  prefix;       // first character in the upper byte
      logic [1:0]           prefix_len;
      logic [FIELD_W-1:0]   zero_count;
      logic [FIELD_W-1:0]   pad_count;
      logic                 left_adjust;
      logic                 lower;
      logic [COUNT_W-1:0]   char_count;
   } fmt_job_type;

   typedef struct packed {
      logic        valid;
      fmt_job_type job;
   } job_chan_type;

endpackage

[hw/rtl/itf_if.sv]
// ----------------------------------------------------------------------------
// itf_req_if / itf_rsp_if
// Valid/ready channels for numbers in and characters out.
// ----------------------------------------------------------------------------
interface itf_req_if;
   logic                               valid;
   logic                               ready;
   logic [itf_pkg::VALUE_W-1:0]        value;
   logic [itf_pkg::MODE_W-1:0]         mode;
   logic                               zero_pad;
   logic                               alt_form;
   logic                               left_adjust;
   logic                               space_sign;
   logic                               plus_sign;
   logic [itf_pkg::FIELD_W-1:0]        field_width;
   logic [itf_pkg::FIELD_W-1:0]        min_digits;

   modport source (
      output valid, value, mode, zero_pad, alt_form, left_adjust,
             space_sign, plus_sign, field_width, min_digits,
      input  ready
   );
   modport sink (
      input  valid, value, mode, zero_pad, alt_form, left_adjust,
             space_sign, plus_sign, field_width, min_digits,
      output ready
   );
endinterface

interface itf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [itf_pkg::CHAR_W-1:0]  out_char;
   logic                        last_char;

   modport source (
      output valid, out_char, last_char,
      input  ready
   );
   modport sink (
      input  valid, out_char, last_char,
      output ready
   );
endinterface

[hw/rtl/itf_front.sv]
// ----------------------------------------------------------------------------
// itf_front
// Accepts a number, picks sign and prefix, converts it to digits and strips
// leading zero digits, then hands a prepared job to the queue.
// ----------------------------------------------------------------------------
module itf_front (
   input  logic                  clock,
   input  logic                  reset,
   itf_req_if.sink               req_if,
   output itf_pkg::job_chan_type push,
   input  logic                  push_ready
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_CONV = 4'b0010,
      F_NORM = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type                   state_ff, state_in;
   logic [itf_pkg::VALUE_W-1:0]       bin_ff, bin_in;
   logic [itf_pkg::BCD_W-1:0]         bcd_ff, bcd_in;
   logic [itf_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [itf_pkg::DIGITS_W-1:0]      digits_ff, digits_in;
   logic [itf_pkg::ND_W-1:0]          nd_ff, nd_in;
   itf_pkg::base_type                 base_ff, base_in;
   logic                              lower_ff, lower_in;
   logic [2*itf_pkg::CHAR_W-1:0]      prefix_ff, prefix_in;
   logic [1:0]                        plen_ff, plen_in;
   logic                              zpad_ff, zpad_in;
   logic                              left_ff, left_in;
   logic [itf_pkg::FIELD_W-1:0]       fw_ff, fw_in;
   logic [itf_pkg::FIELD_W-1:0]       md_ff, md_in;

   // Classification of the incoming word.
   logic [itf_pkg::VALUE_W-1:0]       mag_c;
   itf_pkg::base_type                 base_c;
   logic                              lower_c;
   logic                              alt_c;
   logic [2*itf_pkg::CHAR_W-1:0]      prefix_c;
   logic [1:0]                        plen_c;
   logic [itf_pkg::OCT_EXT_W-1:0]     oct_ext_c;
   logic [itf_pkg::DIGITS_W-1:0]      oct_digits_c;
   logic [itf_pkg::BCD_W-1:0]         bcd_step_c;

   // Count arithmetic for the job.
   logic [itf_pkg::FIELD_W-1:0]       nd_ext_c;
   logic [itf_pkg::FIELD_W-1:0]       zeros_base_c;
   logic [itf_pkg::COUNT_W-1:0]       body_c;
   logic [itf_pkg::COUNT_W-1:0]       fw_ext_c;
   logic [itf_pkg::FIELD_W-1:0]       pad_base_c;

   logic                              accept_c;

   // One shift-and-add-3 step of the binary to BCD conversion.
   function automatic logic [itf_pkg::BCD_W-1:0] dabble_step(
      input logic [itf_pkg::BCD_W-1:0] bcd,
      input logic                      bit_in
   );
      logic [itf_pkg::BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < itf_pkg::BCD_DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      return {adj[itf_pkg::BCD_W-2:0], bit_in};
   endfunction

   assign req_if.ready = (state_ff == F_IDLE);
   assign accept_c     = req_if.valid && (state_ff == F_IDLE);

   always_comb begin
      mag_c    = req_if.value;
      base_c   = itf_pkg::BASE_DEC;
      lower_c  = 1'b0;
      alt_c    = req_if.alt_form;
      prefix_c = '0;
      plen_c   = 2'd0;
      case (req_if.mode)
         itf_pkg::MODE_SDEC: begin
            if (req_if.value[itf_pkg::VALUE_W-1]) begin
               prefix_c = {itf_pkg::CHAR_MINUS, itf_pkg::CHAR_NUL};
               plen_c   = 2'd1;
               mag_c    = '0 - req_if.value;
            end else if (req_if.plus_sign) begin
               prefix_c = {itf_pkg::CHAR_PLUS, itf_pkg::CHAR_NUL};
               plen_c   = 2'd1;
            end else if (req_if.space_sign) begin
               prefix_c = {itf_pkg::CHAR_SPACE, itf_pkg::CHAR_NUL};
               plen_c   = 2'd1;
            end
         end
         itf_pkg::MODE_OCT: begin
            base_c = itf_pkg::BASE_OCT;
         end
         itf_pkg::MODE_HEX_LOWER: begin
            base_c  = itf_pkg::BASE_HEX;
            lower_c = 1'b1;
         end
         itf_pkg::MODE_HEX_UPPER: begin
            base_c = itf_pkg::BASE_HEX;
         end
         itf_pkg::MODE_POINTER: begin
            base_c  = itf_pkg::BASE_HEX;
            lower_c = 1'b1;
            alt_c   = 1'b1;
         end
         default: begin
            base_c = itf_pkg::BASE_DEC;
         end
      endcase
      if (alt_c && (req_if.value != '0)) begin
         if (base_c == itf_pkg::BASE_OCT) begin
            prefix_c = {itf_pkg::CHAR_ZERO, itf_pkg::CHAR_NUL};
            plen_c   = 2'd1;
         end else if (base_c == itf_pkg::BASE_HEX) begin
            prefix_c = {itf_pkg::CHAR_ZERO,
                        lower_c ? itf_pkg::CHAR_X_LOWER : itf_pkg::CHAR_X_UPPER};
            plen_c   = 2'd2;
         end
      end
   end

   // Octal digits are regrouped into nibble slots so every base shares one layout.
   always_comb begin
      oct_ext_c = itf_pkg::OCT_EXT_W'(req_if.value);
      for (int i = 0; i < itf_pkg::SLOT_COUNT; i++) begin
         oct_digits_c[4*i +: 4] = {1'b0, oct_ext_c[3*i +: 3]};
      end
   end

   // Two bits of the binary value enter the BCD register each cycle.
   assign bcd_step_c = dabble_step(dabble_step(bcd_ff, bin_ff[itf_pkg::VALUE_W-1]),
                                   bin_ff[itf_pkg::VALUE_W-2]);

   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      digits_in = digits_ff;
      nd_in     = nd_ff;
      base_in   = base_ff;
      lower_in  = lower_ff;
      prefix_in = prefix_ff;
      plen_in   = plen_ff;
      zpad_in   = zpad_ff;
      left_in   = left_ff;
      fw_in     = fw_ff;
      md_in     = md_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept_c) begin
               base_in   = base_c;
               lower_in  = lower_c;
               prefix_in = prefix_c;
               plen_in   = plen_c;
               zpad_in   = req_if.zero_pad;
               left_in   = req_if.left_adjust;
               fw_in     = (req_if.field_width > itf_pkg::FIELD_W'(itf_pkg::MAX_FIELD))
                           ? itf_pkg::FIELD_W'(itf_pkg::MAX_FIELD) : req_if.field_width;
               md_in     = (req_if.min_digits > itf_pkg::FIELD_W'(itf_pkg::MAX_FIELD))
                           ? itf_pkg::FIELD_W'(itf_pkg::MAX_FIELD) : req_if.min_digits;
               nd_in     = itf_pkg::ND_W'(itf_pkg::SLOT_COUNT);
               bin_in    = mag_c;
               bcd_in    = '0;
               step_in   = itf_pkg::STEP_W'(itf_pkg::VALUE_W / 2 - 1);
               if (base_c == itf_pkg::BASE_DEC) begin
                  state_in = F_CONV;
               end else begin
                  digits_in = (base_c == itf_pkg::BASE_OCT)
                              ? oct_digits_c : itf_pkg::DIGITS_W'(req_if.value);
                  state_in  = F_NORM;
               end
            end
         end
         F_CONV: begin
            bcd_in  = bcd_step_c;
            bin_in  = {bin_ff[itf_pkg::VALUE_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               digits_in = itf_pkg::DIGITS_W'(bcd_step_c);
               state_in  = F_NORM;
            end
         end
         F_NORM: begin
            // Drop one leading zero digit per cycle; at least one digit stays.
            if ((nd_ff > itf_pkg::ND_W'(1)) &&
                (digits_ff[itf_pkg::DIGITS_W-1 -: 4] == 4'd0)) begin
               digits_in = {digits_ff[itf_pkg::DIGITS_W-5:0], 4'd0};
               nd_in     = nd_ff - 1'b1;
            end else begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Zero and pad counts from the digit count, prefix and the two limits.
   always_comb begin
      nd_ext_c     = itf_pkg::FIELD_W'(nd_ff);
      zeros_base_c = (md_ff > nd_ext_c) ? (md_ff - nd_ext_c) : '0;
      if ((base_ff == itf_pkg::BASE_OCT) && (plen_ff != 2'd0) && (zeros_base_c != '0)) begin
         zeros_base_c = zeros_base_c - 1'b1;
      end
      body_c     = itf_pkg::COUNT_W'(plen_ff) + itf_pkg::COUNT_W'(nd_ff) +
                   itf_pkg::COUNT_W'(zeros_base_c);
      fw_ext_c   = itf_pkg::COUNT_W'(fw_ff);
      pad_base_c = (fw_ext_c > body_c) ? itf_pkg::FIELD_W'(fw_ext_c - body_c) : '0;

      push.valid           = (state_ff == F_PUSH);
      push.job.digits      = digits_ff;
      push.job.num_digits  = nd_ff;
      push.job.prefix      = prefix_ff;
      push.job.prefix_len  = plen_ff;
      push.job.left_adjust = left_ff;
      push.job.lower       = lower_ff;
      push.job.char_count  = body_c + itf_pkg::COUNT_W'(pad_base_c);
      if (zpad_ff && !left_ff) begin
         push.job.zero_count = zeros_base_c + pad_base_c;
         push.job.pad_count  = '0;
      end else begin
         push.job.zero_count = zeros_base_c;
         push.job.pad_count  = pad_base_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      step_ff   <= step_in;
      digits_ff <= digits_in;
      nd_ff     <= nd_in;
      base_ff   <= base_in;
      lower_ff  <= lower_in;
      prefix_ff <= prefix_in;
      plen_ff   <= plen_in;
      zpad_ff   <= zpad_in;
      left_ff   <= left_in;
      fw_ff     <= fw_in;
      md_ff     <= md_in;
   end

endmodule

[hw/rtl/itf_queue.sv]
// ----------------------------------------------------------------------------
// itf_queue
// Short FIFO of prepared jobs between the converter and the emitter.
// ----------------------------------------------------------------------------
module itf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  itf_pkg::job_chan_type push,
   output logic                  push_ready,
   output itf_pkg::job_chan_type pop,
   input  logic                  pop_ready
);

   localparam int PTR_W = (itf_pkg::QUEUE_DEPTH > 1) ? $clog2(itf_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(itf_pkg::QUEUE_DEPTH + 1);

   itf_pkg::fmt_job_type entries_ff [itf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push_c;
   logic                 do_pop_c;

   assign push_ready = (count_ff != CNT_W'(itf_pkg::QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.job    = entries_ff[rd_ptr_ff];
   assign do_push_c  = push.valid && push_ready;
   assign do_pop_c   = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push_c) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(itf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop_c) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(itf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push_c && !do_pop_c) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop_c && !do_push_c) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push_c) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

[hw/rtl/itf_back.sv]
// ----------------------------------------------------------------------------
// itf_back
// Takes prepared jobs and emits their characters, one word per cycle while the
// receiver keeps taking them, through a registered output stage.
// ----------------------------------------------------------------------------
module itf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  itf_pkg::job_chan_type pop,
   output logic                  pop_ready,
   itf_rsp_if.source             rsp_if
);

   logic                            busy_ff, busy_in;
   logic [itf_pkg::DIGITS_W-1:0]    digits_ff, digits_in;
   logic [itf_pkg::ND_W-1:0]        nd_ff, nd_in;
   logic [2*itf_pkg::CHAR_W-1:0]    prefix_ff, prefix_in;
   logic [1:0]                      plen_ff, plen_in;
   logic [itf_pkg::FIELD_W-1:0]     zeros_ff, zeros_in;
   logic [itf_pkg::FIELD_W-1:0]     pad_ff, pad_in;
   logic                            left_ff, left_in;
   logic                            lower_ff, lower_in;
   logic [itf_pkg::COUNT_W-1:0]     remain_ff, remain_in;
   logic                            out_valid_ff, out_valid_in;
   logic [itf_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                            last_ff, last_in;

   logic                            emit_c;
   logic [3:0]                      nib_c;
   logic [itf_pkg::CHAR_W-1:0]      digit_char_c;

   assign pop_ready = !busy_ff;
   assign emit_c    = busy_ff && (!out_valid_ff || rsp_if.ready);

   assign nib_c        = digits_ff[itf_pkg::DIGITS_W-1 -: 4];
   assign digit_char_c = (nib_c < 4'd10)
                         ? itf_pkg::CHAR_ZERO + itf_pkg::CHAR_W'(nib_c)
                         : (lower_ff ? itf_pkg::CHAR_A_LOWER : itf_pkg::CHAR_A_UPPER)
                           + itf_pkg::CHAR_W'(nib_c - 4'd10);

   always_comb begin
      busy_in      = busy_ff;
      digits_in    = digits_ff;
      nd_in        = nd_ff;
      prefix_in    = prefix_ff;
      plen_in      = plen_ff;
      zeros_in     = zeros_ff;
      pad_in       = pad_ff;
      left_in      = left_ff;
      lower_in     = lower_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;

      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      if (!busy_ff && pop.valid) begin
         busy_in   = 1'b1;
         digits_in = pop.job.digits;
         nd_in     = pop.job.num_digits;
         prefix_in = pop.job.prefix;
         plen_in   = pop.job.prefix_len;
         zeros_in  = pop.job.zero_count;
         pad_in    = pop.job.pad_count;
         left_in   = pop.job.left_adjust;
         lower_in  = pop.job.lower;
         remain_in = pop.job.char_count;
      end

      if (emit_c) begin
         // Sections go out in order: leading pad, prefix, zeros, digits, trailing pad.
         if (!left_ff && (pad_ff != '0)) begin
            char_in = itf_pkg::CHAR_SPACE;
            pad_in  = pad_ff - 1'b1;
         end else if (plen_ff != 2'd0) begin
            char_in   = prefix_ff[2*itf_pkg::CHAR_W-1 -: itf_pkg::CHAR_W];
            prefix_in = {prefix_ff[itf_pkg::CHAR_W-1:0], itf_pkg::CHAR_NUL};
            plen_in   = plen_ff - 1'b1;
         end else if (zeros_ff != '0) begin
            char_in  = itf_pkg::CHAR_ZERO;
            zeros_in = zeros_ff - 1'b1;
         end else if (nd_ff != '0) begin
            char_in   = digit_char_c;
            digits_in = {digits_ff[itf_pkg::DIGITS_W-5:0], 4'd0};
            nd_in     = nd_ff - 1'b1;
         end else begin
            char_in = itf_pkg::CHAR_SPACE;
            pad_in  = pad_ff - 1'b1;
         end
         out_valid_in = 1'b1;
         last_in      = (remain_ff == itf_pkg::COUNT_W'(1));
         remain_in    = remain_ff - 1'b1;
         busy_in      = (remain_ff != itf_pkg::COUNT_W'(1));
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_char  = char_ff;
   assign rsp_if.last_char = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      nd_ff     <= nd_in;
      prefix_ff <= prefix_in;
      plen_ff   <= plen_in;
      zeros_ff  <= zeros_in;
      pad_ff    <= pad_in;
      left_ff   <= left_in;
      lower_ff  <= lower_in;
      remain_ff <= remain_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

endmodule

[hw/rtl/integer_to_text_formatter_core.sv]
// ----------------------------------------------------------------------------
// integer_to_text_formatter_core
// printf-style rendering of one 64-bit integer into a stream of characters.
// ----------------------------------------------------------------------------
// Each accepted number produces 1 to 62 characters on the response channel,
// one word per cycle while the receiver keeps taking them, the final one
// flagged by last_char. A number first goes through the converter: it is
// taken, then in the decimal modes only converted from binary to BCD two
// bits per cycle, then its leading zero digits are dropped one per cycle,
// and it is handed to a two-entry job queue. The emitter then sends one
// character per cycle while the receiver takes them, and loads the next
// job between numbers. The converter works on the next number while the
// emitter drains the current one. The request channel is ready whenever
// the converter is idle; a full job queue holds the converter busy.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_core (
   input  logic      clock,
   input  logic      reset,
   itf_req_if.sink   req_if,
   itf_rsp_if.source rsp_if
);

   itf_pkg::job_chan_type push;
   itf_pkg::job_chan_type pop;
   logic                  push_ready;
   logic                  pop_ready;

   itf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push       (push),
      .push_ready (push_ready)
   );

   itf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   itf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

[sim/text_format_checker.sv]
// ----------------------------------------------------------------------------
// text_format_checker
// Watches both channels of the integer text formatter, works out the text
// that each accepted number must produce and compares every character word.
// ----------------------------------------------------------------------------
module text_format_checker (
   input  logic              clock,
   input  logic              reset,
   itf_req_if                req,
   itf_rsp_if                rsp,
   output int unsigned       mismatch_count,
   output int unsigned       chars_pending
);

   typedef struct {
      logic [itf_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } text_char_type;

   text_char_type text_expected[$];

   task automatic note_mismatch(input string what, input text_char_type want);
      if (mismatch_count < 10)
         $display("mismatch (%s): expected 0x%02h last=%0b, got 0x%02h last=%0b",
                  what, want.ch, want.last, rsp.out_char, rsp.last_char);
      mismatch_count++;
   endtask

   // Renders one number the printf way and queues its characters.
   function automatic void predict_text(
      input logic [itf_pkg::VALUE_W-1:0] value,
      input logic [itf_pkg::MODE_W-1:0]  mode,
      input logic                        zero_pad,
      input logic                        alt_form,
      input logic                        left_adjust,
      input logic                        space_sign,
      input logic                        plus_sign,
      input logic [itf_pkg::FIELD_W-1:0] field_width,
      input logic [itf_pkg::FIELD_W-1:0] min_digits
   );
      logic [itf_pkg::VALUE_W-1:0] magnitude;
      logic [itf_pkg::VALUE_W-1:0] digit;
      logic [itf_pkg::CHAR_W-1:0]  prefix[2];
      logic [itf_pkg::CHAR_W-1:0]  digit_rev[24];
      logic [itf_pkg::CHAR_W-1:0]  line[$];
      logic                        lower;
      logic                        alt;
      int unsigned                 radix, prefix_len, num_digits, zeros, total, pad;
      int unsigned                 width, precision, i;
      text_char_type               entry;

      width      = (field_width > itf_pkg::MAX_FIELD) ? itf_pkg::MAX_FIELD : field_width;
      precision  = (min_digits > itf_pkg::MAX_FIELD) ? itf_pkg::MAX_FIELD : min_digits;
      radix      = 10;
      lower      = 1'b0;
      alt        = alt_form;
      magnitude  = value;
      prefix_len = 0;
      num_digits = 0;

      if (mode == itf_pkg::MODE_SDEC) begin
         if (value[itf_pkg::VALUE_W-1]) begin
            prefix[prefix_len++] = itf_pkg::CHAR_MINUS;
            magnitude = -value;
         end else if (plus_sign) begin
            prefix[prefix_len++] = itf_pkg::CHAR_PLUS;
         end else if (space_sign) begin
            prefix[prefix_len++] = itf_pkg::CHAR_SPACE;
         end
      end else begin
         case (mode)
            itf_pkg::MODE_OCT: radix = 8;
            itf_pkg::MODE_HEX_LOWER: begin
               radix = 16;
               lower = 1'b1;
            end
            itf_pkg::MODE_HEX_UPPER: radix = 16;
            itf_pkg::MODE_POINTER: begin
               radix = 16;
               lower = 1'b1;
               alt   = 1'b1;
            end
            default: radix = 10;
         endcase
         if (alt && magnitude != '0) begin
            if (radix == 8) begin
               prefix[prefix_len++] = itf_pkg::CHAR_ZERO;
            end else if (radix == 16) begin
               prefix[prefix_len++] = itf_pkg::CHAR_ZERO;
               prefix[prefix_len++] = lower ? itf_pkg::CHAR_X_LOWER : itf_pkg::CHAR_X_UPPER;
            end
         end
      end

      do begin
         digit = magnitude % itf_pkg::VALUE_W'(radix);
         if (digit < 10)
            digit_rev[num_digits] = itf_pkg::CHAR_ZERO + itf_pkg::CHAR_W'(digit);
         else
            digit_rev[num_digits] = (lower ? itf_pkg::CHAR_A_LOWER : itf_pkg::CHAR_A_UPPER)
                                    + itf_pkg::CHAR_W'(digit - 10);
         num_digits++;
         magnitude = magnitude / itf_pkg::VALUE_W'(radix);
      end while (magnitude != '0 && num_digits < 24);

      zeros = (precision > num_digits) ? precision - num_digits : 0;
      // The octal prefix zero stands in for one precision zero.
      if (radix == 8 && prefix_len != 0 && zeros != 0)
         zeros--;
      total = prefix_len + num_digits + zeros;
      pad   = (width > total) ? width - total : 0;
      if (zero_pad && !left_adjust) begin
         zeros += pad;
         pad = 0;
      end

      if (!left_adjust)
         for (i = 0; i < pad; i++) line.push_back(itf_pkg::CHAR_SPACE);
      for (i = 0; i < prefix_len; i++) line.push_back(prefix[i]);
      for (i = 0; i < zeros; i++) line.push_back(itf_pkg::CHAR_ZERO);
      for (i = num_digits; i > 0; i--) line.push_back(digit_rev[i-1]);
      if (left_adjust)
         for (i = 0; i < pad; i++) line.push_back(itf_pkg::CHAR_SPACE);

      foreach (line[k]) begin
         entry.ch   = line[k];
         entry.last = (k == line.size() - 1);
         text_expected.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         text_expected.delete();
         mismatch_count = 0;
      end else begin
         if (req.valid && req.ready)
            predict_text(req.value, req.mode, req.zero_pad, req.alt_form, req.left_adjust,
                         req.space_sign, req.plus_sign, req.field_width, req.min_digits);
         if (rsp.valid && rsp.ready) begin
            if (text_expected.size() == 0) begin
               want.ch   = itf_pkg::CHAR_NUL;
               want.last = 1'b0;
               note_mismatch("no word expected", want);
            end else begin
               want = text_expected.pop_front();
               if (want.ch !== rsp.out_char || want.last !== rsp.last_char)
                  note_mismatch("wrong word", want);
            end
         end
      end
      chars_pending = text_expected.size();
   end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives numbers into the integer text formatter with directed corner cases
// and random traffic, random stalls on both channels, one long output hold
// and one full drain, and reports the verdict from the character checker.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [itf_pkg::MODE_W-1:0]  MODE_SPARE_6  = 3'd6;
   localparam logic [itf_pkg::MODE_W-1:0]  MODE_SPARE_7  = 3'd7;
   localparam logic [itf_pkg::VALUE_W-1:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [itf_pkg::VALUE_W-1:0] INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [itf_pkg::VALUE_W-1:0] ALL_ONES      = '1;
   localparam int RANDOM_ITEMS  = 85;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int STALL_LIMIT   = 3000;

   typedef struct {
      logic [itf_pkg::VALUE_W-1:0] value;
      logic [itf_pkg::MODE_W-1:0]  mode;
      logic                        zero_pad;
      logic                        alt_form;
      logic                        left_adjust;
      logic                        space_sign;
      logic                        plus_sign;
      logic [itf_pkg::FIELD_W-1:0] field_width;
      logic [itf_pkg::FIELD_W-1:0] min_digits;
   } number_req_type;

   logic           clock;
   logic           reset;
   int unsigned    mismatch_count;
   int unsigned    chars_pending;
   int unsigned    sender_idle_pct;
   int unsigned    receiver_idle_pct;
   bit             hold_request;
   int unsigned    stuck_cycles;
   number_req_type directed_reqs[$];

   itf_req_if req_chan ();
   itf_rsp_if rsp_chan ();

   integer_to_text_formatter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   text_format_checker format_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic number_req_type make_req(
      input logic [itf_pkg::VALUE_W-1:0] value,
      input logic [itf_pkg::MODE_W-1:0]  mode,
      input int unsigned zero_pad, input int unsigned alt_form,
      input int unsigned left_adjust,
      input int unsigned space_sign, input int unsigned plus_sign,
      input int unsigned field_width, input int unsigned min_digits
   );
      number_req_type n;
      n.value       = value;
      n.mode        = mode;
      n.zero_pad    = zero_pad[0];
      n.alt_form    = alt_form[0];
      n.left_adjust = left_adjust[0];
      n.space_sign  = space_sign[0];
      n.plus_sign   = plus_sign[0];
      n.field_width = itf_pkg::FIELD_W'(field_width);
      n.min_digits  = itf_pkg::FIELD_W'(min_digits);
      return n;
   endfunction

   function automatic logic [itf_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return itf_pkg::VALUE_W'($urandom_range(0, 20));
         2: return itf_pkg::VALUE_W'(1) << $urandom_range(0, 63);
         3: return -itf_pkg::VALUE_W'($urandom_range(1, 1000));
         4: return {$urandom, $urandom} >> $urandom_range(0, 63);
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return MOST_NEGATIVE;
               2: return INT64_MAX;
               default: return ALL_ONES;
            endcase
         end
      endcase
   endfunction

   // Mostly short fields, now and then anything the 6-bit field allows.
   function automatic int unsigned random_field();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 24);
   endfunction

   // Called at a clock edge; returns at the edge where the word is taken.
   task automatic offer_number(input number_req_type n);
      if ($urandom_range(1, 100) <= sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.value       <= n.value;
      req_chan.mode        <= n.mode;
      req_chan.zero_pad    <= n.zero_pad;
      req_chan.alt_form    <= n.alt_form;
      req_chan.left_adjust <= n.left_adjust;
      req_chan.space_sign  <= n.space_sign;
      req_chan.plus_sign   <= n.plus_sign;
      req_chan.field_width <= n.field_width;
      req_chan.min_digits  <= n.min_digits;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold when asked for.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(1, 100) <= receiver_idle_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      number_req_type item;
      int unsigned    pct_table[4];

      pct_table = '{30, 0, 50, 15};
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.value       <= '0;
      req_chan.mode        <= itf_pkg::MODE_SDEC;
      req_chan.zero_pad    <= 1'b0;
      req_chan.alt_form    <= 1'b0;
      req_chan.left_adjust <= 1'b0;
      req_chan.space_sign  <= 1'b0;
      req_chan.plus_sign   <= 1'b0;
      req_chan.field_width <= '0;
      req_chan.min_digits  <= '0;
      hold_request      = 1'b0;
      sender_idle_pct   = 25;
      receiver_idle_pct = 25;

      // Corner cases: zero, extremes of the value, every mode, sign and
      // prefix rules, padding styles and saturated width and precision.
      directed_reqs.push_back(make_req('0, itf_pkg::MODE_SDEC, 0, 0, 0, 0, 0, 0, 0));
      directed_reqs.push_back(make_req('0, itf_pkg::MODE_POINTER, 0, 1, 0, 0, 0, 0, 0));
      directed_reqs.push_back(make_req('0, itf_pkg::MODE_OCT, 0, 1, 0, 0, 0, 0, 3));
      directed_reqs.push_back(make_req('0, itf_pkg::MODE_SDEC, 0, 0, 0, 0, 1, 0, 0));
      directed_reqs.push_back(make_req(MOST_NEGATIVE, itf_pkg::MODE_SDEC, 0, 0, 0, 1, 1, 0, 0));
      directed_reqs.push_back(make_req(INT64_MAX, itf_pkg::MODE_SDEC, 0, 0, 0, 0, 0, 0, 0));
      directed_reqs.push_back(make_req(ALL_ONES, itf_pkg::MODE_UDEC, 0, 0, 0, 0, 0, 0, 0));
      directed_reqs.push_back(make_req(ALL_ONES, itf_pkg::MODE_OCT, 1, 1, 0, 0, 0, 63, 63));
      directed_reqs.push_back(make_req(ALL_ONES, itf_pkg::MODE_SDEC, 0, 0, 0, 1, 1, 0, 0));
      directed_reqs.push_back(make_req(64'd42, itf_pkg::MODE_SDEC, 0, 0, 0, 0, 1, 0, 0));
      directed_reqs.push_back(make_req(64'd42, itf_pkg::MODE_SDEC, 0, 0, 0, 1, 0, 0, 0));
      directed_reqs.push_back(make_req(64'd42, itf_pkg::MODE_SDEC, 0, 0, 0, 1, 1, 6, 0));
      directed_reqs.push_back(make_req(64'd12345, itf_pkg::MODE_SDEC, 1, 0, 0, 0, 1, 10, 0));
      directed_reqs.push_back(make_req(64'd12345, itf_pkg::MODE_SDEC, 1, 0, 1, 0, 0, 10, 7));
      directed_reqs.push_back(make_req(64'd8, itf_pkg::MODE_OCT, 0, 1, 0, 0, 0, 0, 5));
      directed_reqs.push_back(make_req(64'hDEAD_BEEF, itf_pkg::MODE_HEX_UPPER,
                                       1, 1, 0, 0, 0, 20, 0));
      directed_reqs.push_back(make_req(64'hDEAD_BEEF, itf_pkg::MODE_HEX_LOWER,
                                       0, 1, 1, 1, 1, 20, 12));
      directed_reqs.push_back(make_req(64'h1234, itf_pkg::MODE_POINTER, 0, 0, 0, 0, 0, 0, 0));
      directed_reqs.push_back(make_req(64'h5, itf_pkg::MODE_HEX_LOWER, 0, 1, 0, 0, 0, 0, 63));
      directed_reqs.push_back(make_req(-64'd5, MODE_SPARE_6, 0, 1, 0, 1, 1, 0, 0));
      directed_reqs.push_back(make_req(64'd77, MODE_SPARE_7, 1, 0, 0, 0, 0, 8, 0));
      directed_reqs.push_back(make_req(64'd99, itf_pkg::MODE_UDEC, 0, 1, 0, 1, 1, 0, 1));
      directed_reqs.push_back(make_req(64'd7, itf_pkg::MODE_SDEC, 0, 0, 0, 0, 0, 61, 0));
      directed_reqs.push_back(make_req(64'd7, itf_pkg::MODE_HEX_UPPER, 1, 0, 1, 0, 0, 63, 0));
      directed_reqs.push_back(make_req(ALL_ONES, itf_pkg::MODE_HEX_UPPER, 0, 1, 0, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_reqs[k]) offer_number(directed_reqs[k]);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k >= RANDOM_ITEMS - 20) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else begin
            sender_idle_pct   = pct_table[(k / 15) % 4];
            receiver_idle_pct = pct_table[(k / 15 + 1) % 4];
         end
         // The output holds off while numbers keep coming, filling the block.
         if (k == 35)
            hold_request = 1'b1;
         // Let every character drain before going on.
         if (k == 65) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (chars_pending != 0) @(posedge clock);
         end
         item = make_req(random_value(), itf_pkg::MODE_W'($urandom_range(0, 7)),
                         $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1),
                         random_field(), random_field());
         offer_number(item);
      end
      req_chan.valid <= 1'b0;

      // The checker counts the last number at the edge it was taken.
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
